// ===== design/cklt_pkg.sv =====
// shared types, codes and hash helpers for the cuckoo key-label table
`default_nettype none
package cklt_pkg;

  localparam int unsigned KeyW   = 16;
  localparam int unsigned LabelW = 8;
  localparam int unsigned EntryW = 25;
  localparam logic [31:0] CrcPoly = 32'h82F63B78;
  localparam logic [15:0] AltMultLo = 16'hE995;

  typedef logic [1:0] status_t;
  localparam status_t StOk     = 2'd0;
  localparam status_t StMiss   = 2'd1;
  localparam status_t StExists = 2'd2;
  localparam status_t StFull   = 2'd3;

  localparam logic CmdLookup = 1'b0;
  localparam logic CmdInsert = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [KeyW-1:0]   key;
    logic [LabelW-1:0] label;
  } entry_t;

  // crc32c contribution of one key bit; evaluated only on constants
  function automatic logic [31:0] crc_col(int unsigned bit_idx);
    logic [63:0] data;
    logic [31:0] crc;
    data = 64'd1 << bit_idx;
    crc  = '0;
    for (int b = 0; b < 8; b++) begin
      crc  = crc ^ {24'd0, data[7:0]};
      data = data >> 8;
      for (int k = 0; k < 8; k++) begin
        crc = (crc >> 1) ^ (crc[0] ? CrcPoly : 32'd0);
      end
    end
    return crc;
  endfunction

endpackage
`default_nettype wire

// ===== design/cklt_ram.sv =====
// generic single-port ram with registered read
`default_nettype none
module cklt_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write or registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule
`default_nettype wire

// ===== design/cklt_hash.sv =====
// primary and alternate bucket of a key
`default_nettype none
module cklt_hash #(
  parameter int unsigned BW = 10
) (
  input  wire logic [cklt_pkg::KeyW-1:0] key_i,
  output logic      [BW-1:0]             primary_o,
  output logic      [BW-1:0]             alternate_o
);
  import cklt_pkg::*;

  logic [31:0] cols [KeyW];
  logic [31:0] hash;
  logic [15:0] tag;
  logic [15:0] prod;

  // crc is linear in the key bits
  for (genvar gi = 0; gi < KeyW; gi++) begin : g_col
    assign cols[gi] = crc_col(gi);
  end

  always_comb begin
    hash = '0;
    for (int i = 0; i < KeyW; i++) begin
      hash = hash ^ (key_i[i] ? cols[i] : 32'd0);
    end
  end

  // only the low bits of the product reach the half mask
  assign tag  = 16'(hash >> BW);
  assign prod = 16'((tag + 16'd1) * AltMultLo);
  assign primary_o   = hash[BW-1:0];
  assign alternate_o = {1'b0, primary_o[BW-2:0] ^ prod[BW-2:0]};

endmodule
`default_nettype wire

// ===== design/cuckoo_key_label_table_unit.sv =====
// top level of the cuckoo key-label table
// Maps 16-bit keys to 8-bit labels in BUCKET_COUNT buckets of WAYS ways.
// Input channel (in_valid_i / in_stall_o) carries cmd_i (0 lookup, 1 insert),
// key_i and new_label_i. Output channel (out_valid_o / out_stall_i) carries
// status_o (0 ok/hit, 1 not found, 2 exists, 3 full) and found_label_o.
// One result per transaction, in order. One item is worked on at a time.
// The store is one row per bucket in a single-port ram, so the two bucket
// reads of a lookup or plain insert run one after the other (S_RD1, S_RD2,
// then S_CHK); an insert that relocates goes through S_VHASH, S_VRD and
// S_VCHK for each victim tried, up to WAYS victims, and then S_WRB1. The
// next transaction is taken only after the result is formed, so one item
// is through before the next is accepted.
// The output register holds a finished result while the next transaction
// is taken; if the receiver stalls, a second result waits until it drains.
// After reset a clearing pass writes every row to empty, and in_stall_o
// stays high throughout that pass.
`default_nettype none
module cuckoo_key_label_table_unit #(
  parameter int unsigned BUCKET_COUNT = 1024,
  parameter int unsigned WAYS = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          cmd_i,
  input  wire logic [cklt_pkg::KeyW-1:0]     key_i,
  input  wire logic [cklt_pkg::LabelW-1:0]   new_label_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output cklt_pkg::status_t                  status_o,
  output logic      [cklt_pkg::LabelW-1:0]   found_label_o
);
  import cklt_pkg::*;

  localparam int unsigned BW   = $clog2(BUCKET_COUNT);
  localparam int unsigned WIW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RowW = WAYS * EntryW;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_RD1   = 10'b0000000100,
    S_RD2   = 10'b0000001000,
    S_CHK   = 10'b0000010000,
    S_VHASH = 10'b0000100000,
    S_VRD   = 10'b0001000000,
    S_VCHK  = 10'b0010000000,
    S_WRB1  = 10'b0100000000,
    S_RESP  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [BW-1:0] clr_q, clr_d;
  logic cmd_q;
  logic [KeyW-1:0] key_q;
  logic [LabelW-1:0] lbl_q;
  logic [BW-1:0] b1_q, b2_q, v2_q;
  logic [RowW-1:0] row1_q;
  logic [WIW-1:0] vi_q, vi_d;
  status_t res_st_q, res_st_d;
  logic [LabelW-1:0] res_lbl_q, res_lbl_d;
  logic out_valid_q;
  status_t out_st_q;
  logic [LabelW-1:0] out_lbl_q;

  logic ram_we;
  logic [BW-1:0] ram_addr;
  logic [RowW-1:0] ram_wdata, ram_rdata;
  logic [KeyW-1:0] hkey;
  logic [BW-1:0] h_pri, h_alt;
  entry_t victim, new_ent;

  cklt_ram #(.WIDTH(RowW), .DEPTH(BUCKET_COUNT)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // one hash unit shared by the new key and the victims
  assign hkey = (state_q == S_IDLE) ? key_i : victim.key;

  cklt_hash #(.BW(BW)) u_hash (
    .key_i      (hkey),
    .primary_o  (h_pri),
    .alternate_o(h_alt)
  );

  assign victim  = entry_t'(row1_q[vi_q*EntryW +: EntryW]);
  assign new_ent = '{valid: 1'b1, key: key_q, label: lbl_q};

  // bucket scans: matches in both rows, free ways in primary and victim rows
  logic hit1, hit2, free1, free_v;
  logic [LabelW-1:0] lbl1, lbl2;
  logic [WIW-1:0] free1_w, free_v_w;
  always_comb begin
    entry_t e1, e2;
    hit1 = 1'b0; hit2 = 1'b0; free1 = 1'b0; free_v = 1'b0;
    lbl1 = '0; lbl2 = '0; free1_w = '0; free_v_w = '0;
    for (int w = 0; w < WAYS; w++) begin
      e1 = entry_t'(row1_q[w*EntryW +: EntryW]);
      e2 = entry_t'(ram_rdata[w*EntryW +: EntryW]);
      if (!hit1 && e1.valid && e1.key == key_q) begin
        hit1 = 1'b1; lbl1 = e1.label;
      end
      if (!hit2 && e2.valid && e2.key == key_q) begin
        hit2 = 1'b1; lbl2 = e2.label;
      end
      if (!free1 && !e1.valid) begin
        free1 = 1'b1; free1_w = WIW'(w);
      end
      if (!free_v && !e2.valid) begin
        free_v = 1'b1; free_v_w = WIW'(w);
      end
    end
  end

  // sequencer and ram port
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    vi_d      = vi_q;
    res_st_d  = res_st_q;
    res_lbl_d = res_lbl_q;
    ram_we    = 1'b0;
    ram_addr  = b1_q;
    ram_wdata = row1_q;
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + BW'(1);
        if (clr_q == BW'(BUCKET_COUNT - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_RD1;
      end
      S_RD1: begin
        ram_addr = b1_q;
        state_d  = S_RD2;
      end
      S_RD2: begin
        ram_addr = b2_q;
        state_d  = S_CHK;
      end
      S_CHK: begin
        res_lbl_d = '0;
        state_d   = S_RESP;
        if (hit1 || hit2) begin
          if (cmd_q == CmdLookup) begin
            res_st_d  = StOk;
            res_lbl_d = hit1 ? lbl1 : lbl2;
          end else begin
            res_st_d = StExists;
          end
        end else if (cmd_q == CmdLookup) begin
          res_st_d = StMiss;
        end else if (free1) begin
          ram_we    = 1'b1;
          ram_addr  = b1_q;
          ram_wdata = row1_q;
          ram_wdata[free1_w*EntryW +: EntryW] = new_ent;
          res_st_d  = StOk;
        end else begin
          vi_d    = '0;
          state_d = S_VHASH;
        end
      end
      S_VHASH: begin
        if (h_pri == h_alt || b1_q == h_alt) begin
          res_st_d = StFull;
          state_d  = S_RESP;
        end else begin
          state_d = S_VRD;
        end
      end
      S_VRD: begin
        ram_addr = v2_q;
        state_d  = S_VCHK;
      end
      S_VCHK: begin
        if (free_v) begin
          ram_we    = 1'b1;
          ram_addr  = v2_q;
          ram_wdata = ram_rdata;
          ram_wdata[free_v_w*EntryW +: EntryW] = victim;
          state_d   = S_WRB1;
        end else if (vi_q == WIW'(WAYS - 1)) begin
          res_st_d = StFull;
          state_d  = S_RESP;
        end else begin
          vi_d    = vi_q + WIW'(1);
          state_d = S_VHASH;
        end
      end
      S_WRB1: begin
        ram_we    = 1'b1;
        ram_addr  = b1_q;
        ram_wdata = row1_q;
        ram_wdata[vi_q*EntryW +: EntryW] = new_ent;
        res_st_d  = StOk;
        state_d   = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (state_q == S_RESP && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    vi_q      <= vi_d;
    res_st_q  <= res_st_d;
    res_lbl_q <= res_lbl_d;
    if (state_q == S_IDLE && in_valid_i) begin
      cmd_q <= cmd_i;
      key_q <= key_i;
      lbl_q <= new_label_i;
      b1_q  <= h_pri;
      b2_q  <= h_alt;
    end
    if (state_q == S_RD2) row1_q <= ram_rdata;
    if (state_q == S_VHASH) v2_q <= h_alt;
    if (state_q == S_RESP && (!out_valid_q || !out_stall_i)) begin
      out_st_q  <= res_st_q;
      out_lbl_q <= res_lbl_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_st_q;
  assign found_label_o = out_lbl_q;

  // an accepted transaction blocks the input until its result is formed
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted twice in a row");

  // relocation never writes the victim into the new key's primary bucket
  a_victim_bucket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_VCHK && ram_we |-> v2_q != b1_q)
    else $error("victim moved into primary bucket");

  // a label is reported only with a hit
  a_label_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StOk |-> found_label_o == '0)
    else $error("label reported without hit");

endmodule
`default_nettype wire

// ===== tb/tb_cuckoo_key_label_table_unit.sv =====
// cuckoo key-label table bench: directed and random lookups, inserts checked against a predictor
`default_nettype none
module tb_cuckoo_key_label_table_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import cklt_pkg::*;

  localparam int unsigned Buckets = 1024;
  localparam int unsigned Ways = 4;
  localparam int unsigned LogB = 10;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic              cmd;
    logic [KeyW-1:0]   key;
    logic [LabelW-1:0] label;
  } op_t;

  typedef struct packed {
    status_t           status;
    logic [LabelW-1:0] label;
  } answer_t;

  logic clk, rst_n;
  logic in_valid, in_stall, cmd;
  logic [KeyW-1:0] key;
  logic [LabelW-1:0] new_label;
  logic out_valid, out_stall;
  status_t status;
  logic [LabelW-1:0] found_label;
  logic in_stall_seen;

  cuckoo_key_label_table_unit uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .cmd_i(cmd), .key_i(key), .new_label_i(new_label),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .found_label_o(found_label)
  );

  op_t     pending_ops[$];
  answer_t expected_answers[$];
  logic [EntryW-1:0] table_model[Buckets*Ways];
  logic [KeyW-1:0] used_keys[$];
  int error_count = 0;
  int cycle_count = 0;
  bit stimulus_done = 0;
  bit quiet_phase = 0;
  bit hold_phase = 0;
  int hold_cycles = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // crc32c of the zero-extended key, bytewise lsb first
  function automatic logic [31:0] crc_of_key(logic [KeyW-1:0] k);
    logic [63:0] data;
    logic [31:0] crc;
    data = {48'd0, k};
    crc = '0;
    for (int b = 0; b < 8; b++) begin
      crc = crc ^ {24'd0, data[7:0]};
      data = data >> 8;
      for (int i = 0; i < 8; i++) begin
        crc = (crc >> 1) ^ (crc[0] ? 32'h82F63B78 : 32'd0);
      end
    end
    return crc;
  endfunction

  function automatic int unsigned home_bucket(logic [31:0] h);
    return h & (Buckets - 1);
  endfunction

  function automatic int unsigned spare_bucket(logic [31:0] h, int unsigned idx);
    logic [63:0] tag;
    tag = (64'(h >> LogB) + 64'd1) * 64'h5bd1e995;
    return int'((64'(idx) ^ tag) & 64'((Buckets / 2) - 1));
  endfunction

  function automatic bit scan_bucket(int unsigned b, logic [KeyW-1:0] k,
                                     output logic [LabelW-1:0] lbl);
    logic [EntryW-1:0] e;
    lbl = '0;
    for (int w = 0; w < Ways; w++) begin
      e = table_model[b*Ways + w];
      if (e[24] && e[23:8] == k) begin
        lbl = e[7:0];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit locate_key(logic [KeyW-1:0] k, output logic [LabelW-1:0] lbl);
    logic [31:0] h;
    int unsigned b1;
    h = crc_of_key(k);
    b1 = home_bucket(h);
    if (scan_bucket(b1, k, lbl)) return 1'b1;
    return scan_bucket(spare_bucket(h, b1), k, lbl);
  endfunction

  function automatic status_t place_key(logic [KeyW-1:0] k, logic [LabelW-1:0] lbl);
    logic [LabelW-1:0] dummy;
    logic [EntryW-1:0] victim;
    logic [31:0] vh;
    int unsigned b1, v1, v2;
    if (locate_key(k, dummy)) return StExists;
    b1 = home_bucket(crc_of_key(k));
    for (int i = 0; i < Ways; i++) begin
      if (!table_model[b1*Ways + i][24]) begin
        table_model[b1*Ways + i] = {1'b1, k, lbl};
        return StOk;
      end
    end
    // relocate one victim into its alternate bucket
    for (int i = 0; i < Ways; i++) begin
      victim = table_model[b1*Ways + i];
      vh = crc_of_key(victim[23:8]);
      v1 = home_bucket(vh);
      v2 = spare_bucket(vh, v1);
      if (v1 == v2 || b1 == v2) return StFull;
      for (int j = 0; j < Ways; j++) begin
        if (!table_model[v2*Ways + j][24]) begin
          table_model[v2*Ways + j] = victim;
          table_model[b1*Ways + i] = {1'b1, k, lbl};
          return StOk;
        end
      end
    end
    return StFull;
  endfunction

  function automatic answer_t predict_answer(op_t op);
    answer_t a;
    logic [LabelW-1:0] lbl;
    a = '0;
    if (op.cmd == CmdLookup) begin
      if (locate_key(op.key, lbl)) begin
        a.status = StOk;
        a.label = lbl;
      end else begin
        a.status = StMiss;
      end
    end else begin
      a.status = place_key(op.key, op.label);
    end
    return a;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // keys that crowd a few buckets: a small pool so that relocation and full occur
  function automatic logic [KeyW-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45 && used_keys.size() > 0) return used_keys[$urandom_range(0, used_keys.size() - 1)];
    if (r < 75) return KeyW'($urandom_range(0, 255) * 256);
    return KeyW'($urandom);
  endfunction

  // stimulus
  initial begin
    op_t op;
    foreach (table_model[i]) table_model[i] = '0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // directed part
    pending_ops.push_back({CmdLookup, 16'h0000, 8'h00});
    pending_ops.push_back({CmdInsert, 16'h0000, 8'hFF});
    pending_ops.push_back({CmdInsert, 16'h0000, 8'h12});
    pending_ops.push_back({CmdLookup, 16'h0000, 8'hAA});
    pending_ops.push_back({CmdInsert, 16'hFFFF, 8'h00});
    pending_ops.push_back({CmdLookup, 16'hFFFF, 8'h55});
    pending_ops.push_back({CmdLookup, 16'h5A5A, 8'h00});
    for (int i = 0; i < 14; i++) begin
      pending_ops.push_back({CmdInsert, KeyW'(i * 4096 + 1), LabelW'(i * 17)});
    end
    pending_ops.push_back({CmdLookup, 16'h0001, 8'h00});
    pending_ops.push_back({CmdLookup, 16'hD001, 8'h00});
    for (int i = 0; i < 1850; i++) begin
      op.cmd = ($urandom_range(0, 99) < 55) ? CmdInsert : CmdLookup;
      op.key = pick_key();
      op.label = LabelW'($urandom);
      if (op.cmd == CmdInsert && used_keys.size() < 600) used_keys.push_back(op.key);
      pending_ops.push_back(op);
    end
    stimulus_done = 1'b1;
  end

  // cycle count and quiet stretch with no idling
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == 3000) quiet_phase <= 1'b1;
    if (cycle_count == 5000) quiet_phase <= 1'b0;
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (cycle_count == 7000) hold_phase <= 1'b1;
    if (hold_phase) begin
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles == 300) hold_phase <= 1'b0;
    end
  end

  // driver
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      cmd <= CmdLookup;
      key <= '0;
      new_label <= '0;
    end else if (!in_valid || !in_stall_seen) begin
      if (pending_ops.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= 9)) begin
        op_t op;
        op = pending_ops.pop_front();
        expected_answers.push_back(predict_answer(op));
        in_valid <= 1'b1;
        cmd <= op.cmd;
        key <= op.key;
        new_label <= op.label;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // input stall seen at the last rising edge
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) in_stall_seen <= 1'b1;
    else in_stall_seen <= in_valid && in_stall;
  end

  // receiver stall
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= hold_phase || (!quiet_phase && $urandom_range(0, 99) < 9);
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_answers.size() == 0) begin
        report_mismatch("unexpected transaction", status, -1);
      end else begin
        answer_t a;
        a = expected_answers.pop_front();
        if (status !== a.status) report_mismatch("status", status, a.status);
        if (found_label !== a.label) report_mismatch("found_label", found_label, a.label);
      end
    end
  end

  // end of run
  initial begin
    wait (stimulus_done);
    while ((pending_ops.size() > 0 || in_valid || expected_answers.size() > 0)
           && cycle_count < CycleLimit) @(posedge clk);
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      repeat (40) @(posedge clk);
      if (error_count == 0 && expected_answers.size() == 0) begin
        $display("simulation ok");
      end else begin
        $display("simulation failed");
      end
      $finish;
    end
  end
endmodule
`default_nettype wire

// ===== files.f =====
design/cklt_pkg.sv
design/cklt_ram.sv
design/cklt_hash.sv
design/cuckoo_key_label_table_unit.sv
tb/tb_cuckoo_key_label_table_unit.sv
